// ----- hw/rtl/gpc_pkg.sv -----
// Package: shared constants, codes and port structs of the pair coloring block.
`timescale 1ns / 1ps
package gpc_pkg;

  localparam int MaxPairs       = 64;
  localparam int PairIdxW       = $clog2(MaxPairs);
  localparam int PairCntW       = PairIdxW + 1;
  localparam int MaxObjects     = 256;
  localparam int ObjIdW         = $clog2(MaxObjects);
  localparam int MaxObjsPerPair = 8;
  localparam int ObjIdxW        = $clog2(MaxObjsPerPair);
  localparam int ObjCntW        = ObjIdxW + 1;
  localparam int WeightW        = 16;
  localparam int ColorW         = 6;
  localparam int MarkW          = ColorW + 1;
  localparam int ColorMax       = 63;
  localparam int KeyW           = ColorW + WeightW + PairIdxW;

  typedef enum logic [1:0] {
    MODE_OBJ    = 2'd0,
    MODE_CLOSE  = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_PAIR  = 2'd0,
    KIND_SET   = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_OBJ_OVFL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OBJ_RD,
    ST_CLOSE,
    ST_MARK_WR,
    ST_EMIT_CLOSE,
    ST_EMIT_FULL,
    ST_EMIT_EMPTY,
    ST_SCAN,
    ST_EMIT_SET
  } state_e;

  // mark table write port
  typedef struct packed {
    logic              en;
    logic [ObjIdW-1:0] addr;
    logic [MarkW-1:0]  data;
  } mark_wr_t;

  // pair table write port
  typedef struct packed {
    logic                en;
    logic [PairIdxW-1:0] addr;
    logic [ColorW-1:0]   color;
    logic [WeightW-1:0]  weight;
  } pair_wr_t;

  // pair table read data
  typedef struct packed {
    logic [ColorW-1:0]  color;
    logic [WeightW-1:0] weight;
  } pair_rd_t;

endpackage

// ----- hw/rtl/gpc_mark_mem.sv -----
// Object mark table: memory plus per-entry valid bits, cleared at once on finish.
`timescale 1ns / 1ps
module gpc_mark_mem import gpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  mark_wr_t          wr_i,
  input  logic [ObjIdW-1:0] rd_addr_i,
  output logic [MarkW-1:0]  rd_data_o
);

  logic [MarkW-1:0]      mem_q [MaxObjects];
  logic [MaxObjects-1:0] vld_q;
  logic [MarkW-1:0]      rd_q;

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // valid bits: unwritten entries read as none
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_i) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rd_q <= vld_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
  end

  assign rd_data_o = rd_q;

endmodule

// ----- hw/rtl/gpc_pair_mem.sv -----
// Pair table: color and weight per stored pair, one write and one registered read.
`timescale 1ns / 1ps
module gpc_pair_mem import gpc_pkg::*; (
  input  logic                clk_i,
  input  pair_wr_t            wr_i,
  input  logic [PairIdxW-1:0] rd_addr_i,
  output pair_rd_t            rd_data_o
);

  pair_rd_t mem_q [MaxPairs];
  pair_rd_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= '{color: wr_i.color, weight: wr_i.weight};
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

// ----- hw/rtl/greedy_partition_pair_coloring.sv -----
// Top level: sequencer and shared key comparator of the greedy pair coloring block.
//
//  channel  | dir | handshake                   | payload
//  s_axis   | in  | s_axis_tvalid/tready        | tuser mode, tdata object_id, constraint_count
//  m_axis   | out | m_axis_tvalid/tready        | tuser kind, tdata pair_index, color, status
//  cfg      | in  | cfg_valid_i/cfg_ready_o     | cfg_data_i first_set_count
//
// Object word: mark read, then running max update. Close: pair write, one mark write per
// object in the pair, then the result word. Finish: each listed word is one full scan of
// the pair table through the single key comparator, pair table read port sets the pace.
// Reset clears all control state and the mark valid bits; no clearing pass.
// A stalled m_axis holds the sequencer in its emit state; s_axis waits meanwhile.
`timescale 1ns / 1ps
module greedy_partition_pair_coloring import gpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // object_id [7:0], constraint_count [23:8]
  input  logic [1:0]  s_axis_tuser,  // mode [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // pair_index [5:0], color [11:6], status [13:12]
  output logic [1:0]  m_axis_tuser,  // kind [1:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);

  state_e state_q, state_d;

  logic [ObjCntW-1:0]  cnt_q, cnt_d;
  logic                ovf_q, ovf_d;
  logic [MarkW-1:0]    runmax_q, runmax_d;
  logic [PairCntW-1:0] pairs_q, pairs_d;
  logic [ObjIdW-1:0]   obj_q [MaxObjsPerPair];
  logic                obj_we;
  logic [6:0]          fsc_q;
  logic [WeightW-1:0]  weight_q, weight_d;
  logic [ColorW-1:0]   color_q, color_d;
  logic [ObjCntW-1:0]  iter_q, iter_d;
  logic [PairCntW-1:0] scan_q, scan_d;
  logic                pend_q, pend_d;
  logic [PairIdxW-1:0] rd_idx_q, rd_idx_d;
  logic                best_v_q, best_v_d;
  logic [KeyW-1:0]     best_q, best_d;
  logic [KeyW-1:0]     lastkey_q, lastkey_d;
  logic                first_q, first_d;
  logic [PairCntW-1:0] emit_q, emit_d;

  logic                out_v_q;
  logic [1:0]          out_kind_q, out_kind_d;
  logic [PairIdxW-1:0] out_idx_q, out_idx_d;
  logic [ColorW-1:0]   out_color_q, out_color_d;
  logic [1:0]          out_stat_q, out_stat_d;
  logic                out_last_q, out_last_d;
  logic                out_load, out_free;

  logic                accept;
  mode_e               mode;
  logic [ObjIdW-1:0]   in_obj;
  logic                clr;
  mark_wr_t            mark_wr;
  logic [ObjIdW-1:0]   mark_rd_addr;
  logic [MarkW-1:0]    mark_rd;
  pair_wr_t            pair_wr;
  logic [PairIdxW-1:0] pair_rd_addr;
  pair_rd_t            pair_rd;
  logic [ColorW-1:0]   new_color;
  logic [KeyW-1:0]     cand;
  logic                take;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign mode          = mode_e'(s_axis_tuser);
  assign in_obj        = s_axis_tdata[ObjIdW-1:0];
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_v_q || m_axis_tready;

  // memories
  gpc_mark_mem u_mark (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (clr),
    .wr_i     (mark_wr),
    .rd_addr_i(mark_rd_addr),
    .rd_data_o(mark_rd)
  );

  gpc_pair_mem u_pair (
    .clk_i    (clk_i),
    .wr_i     (pair_wr),
    .rd_addr_i(pair_rd_addr),
    .rd_data_o(pair_rd)
  );

  // color of the pair being closed, saturated
  always_comb begin
    if (pairs_q < fsc_q) begin
      new_color = '0;
    end else if (runmax_q > MarkW'(ColorMax)) begin
      new_color = ColorW'(ColorMax);
    end else begin
      new_color = runmax_q[ColorW-1:0];
    end
  end

  // shared comparator: next key above the last listed one, smallest such
  assign cand = {pair_rd.color, ~pair_rd.weight, rd_idx_q};
  assign take = pend_q && (first_q || (cand > lastkey_q)) && (!best_v_q || (cand < best_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_OBJ:    state_d = (cnt_q < ObjCntW'(MaxObjsPerPair)) ? ST_OBJ_RD : ST_IDLE;
            MODE_CLOSE:  state_d = (pairs_q >= PairCntW'(MaxPairs)) ? ST_EMIT_FULL : ST_CLOSE;
            MODE_FINISH: state_d = (pairs_q == '0) ? ST_EMIT_EMPTY : ST_SCAN;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_OBJ_RD:  state_d = ST_IDLE;
      ST_CLOSE:   state_d = ST_MARK_WR;
      ST_MARK_WR: if (iter_q >= cnt_q) state_d = ST_EMIT_CLOSE;
      ST_EMIT_CLOSE, ST_EMIT_FULL, ST_EMIT_EMPTY: if (out_free) state_d = ST_IDLE;
      ST_SCAN:    if (scan_q == pairs_q && !pend_q) state_d = ST_EMIT_SET;
      ST_EMIT_SET: begin
        if (out_free) state_d = (emit_q + 1'b1 == pairs_q) ? ST_IDLE : ST_SCAN;
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d        = cnt_q;
    ovf_d        = ovf_q;
    runmax_d     = runmax_q;
    pairs_d      = pairs_q;
    obj_we       = 1'b0;
    weight_d     = weight_q;
    color_d      = color_q;
    iter_d       = iter_q;
    scan_d       = scan_q;
    pend_d       = 1'b0;
    rd_idx_d     = scan_q[PairIdxW-1:0];
    best_v_d     = best_v_q || take;
    best_d       = take ? cand : best_q;
    lastkey_d    = lastkey_q;
    first_d      = first_q;
    emit_d       = emit_q;
    clr          = 1'b0;
    mark_wr      = '0;
    mark_rd_addr = in_obj;
    pair_wr      = '0;
    pair_rd_addr = scan_q[PairIdxW-1:0];
    out_load     = 1'b0;
    out_kind_d   = KIND_PAIR;
    out_idx_d    = '0;
    out_color_d  = '0;
    out_stat_d   = STAT_OK;
    out_last_d   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          weight_d = s_axis_tdata[ObjIdW +: WeightW];
          scan_d   = '0;
          best_v_d = 1'b0;
          first_d  = 1'b1;
          emit_d   = '0;
          iter_d   = '0;
          if (mode == MODE_OBJ) begin
            if (cnt_q < ObjCntW'(MaxObjsPerPair)) begin
              obj_we = 1'b1;
              cnt_d  = cnt_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
      end
      ST_OBJ_RD: begin
        if (mark_rd > runmax_q) runmax_d = mark_rd;
      end
      ST_CLOSE: begin
        color_d = new_color;
        pair_wr = '{en: 1'b1, addr: pairs_q[PairIdxW-1:0], color: new_color,
                    weight: weight_q};
      end
      ST_MARK_WR: begin
        if (iter_q < cnt_q) begin
          mark_wr = '{en: 1'b1, addr: obj_q[iter_q[ObjIdxW-1:0]],
                      data: {1'b0, color_q} + 1'b1};
          iter_d  = iter_q + 1'b1;
        end
      end
      ST_EMIT_CLOSE: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_idx_d   = pairs_q[PairIdxW-1:0];
          out_color_d = color_q;
          out_stat_d  = ovf_q ? STAT_OBJ_OVFL : STAT_OK;
          pairs_d     = pairs_q + 1'b1;
          cnt_d       = '0;
          ovf_d       = 1'b0;
          runmax_d    = '0;
        end
      end
      ST_EMIT_FULL: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_stat_d = STAT_FULL;
          cnt_d      = '0;
          ovf_d      = 1'b0;
          runmax_d   = '0;
        end
      end
      ST_EMIT_EMPTY: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = KIND_EMPTY;
          out_last_d = 1'b1;
          clr        = 1'b1;
          cnt_d      = '0;
          ovf_d      = 1'b0;
          runmax_d   = '0;
        end
      end
      ST_SCAN: begin
        if (scan_q < pairs_q) begin
          pend_d = 1'b1;
          scan_d = scan_q + 1'b1;
        end
      end
      ST_EMIT_SET: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_kind_d  = KIND_SET;
          out_idx_d   = best_q[PairIdxW-1:0];
          out_color_d = best_q[KeyW-1 -: ColorW];
          out_last_d  = (emit_q + 1'b1 == pairs_q);
          lastkey_d   = best_q;
          first_d     = 1'b0;
          emit_d      = emit_q + 1'b1;
          scan_d      = '0;
          best_v_d    = 1'b0;
          if (emit_q + 1'b1 == pairs_q) begin
            clr      = 1'b1;
            pairs_d  = '0;
            cnt_d    = '0;
            ovf_d    = 1'b0;
            runmax_d = '0;
          end
        end
      end
      default: begin
        clr = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      runmax_q <= '0;
      pairs_q  <= '0;
      fsc_q    <= '0;
      iter_q   <= '0;
      scan_q   <= '0;
      pend_q   <= 1'b0;
      best_v_q <= 1'b0;
      first_q  <= 1'b1;
      emit_q   <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      runmax_q <= runmax_d;
      pairs_q  <= pairs_d;
      iter_q   <= iter_d;
      scan_q   <= scan_d;
      pend_q   <= pend_d;
      best_v_q <= best_v_d;
      first_q  <= first_d;
      emit_q   <= emit_d;
      if (cfg_valid_i && cfg_ready_o) fsc_q <= cfg_data_i;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (obj_we) obj_q[cnt_q[ObjIdxW-1:0]] <= in_obj;
    weight_q  <= weight_d;
    color_q   <= color_d;
    rd_idx_q  <= rd_idx_d;
    best_q    <= best_d;
    lastkey_q <= lastkey_d;
    if (out_load) begin
      out_kind_q  <= out_kind_d;
      out_idx_q   <= out_idx_d;
      out_color_q <= out_color_d;
      out_stat_q  <= out_stat_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_stat_q, out_color_q, out_idx_q};

endmodule

// ----- hw/rtl/gpc_checker.sv -----
// Port-level checker for the pair coloring block, bound to the top level.
`timescale 1ns / 1ps
module gpc_checker import gpc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result word changed under stall");

  // close and finish words always start work that holds the input off
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready
      && (s_axis_tuser == MODE_CLOSE || s_axis_tuser == MODE_FINISH) |=> !s_axis_tready)
    else $error("input ready right after close or finish");

  // empty finish is always the last word of its listing
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_EMPTY |-> m_axis_tlast)
    else $error("empty finish without tlast");

  // close results never carry tlast
  a_close_nolast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_PAIR |-> !m_axis_tlast)
    else $error("close result with tlast");

endmodule

bind greedy_partition_pair_coloring gpc_checker u_gpc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

// ----- verif/testbench.sv -----
// Testbench: random and directed pair streams against a scoreboard predictor of the coloring block.
`timescale 1ns / 1ps
module testbench;
  import gpc_pkg::*;

  // one expected output word
  typedef struct packed {
    kind_e            kind;
    logic [5:0]       idx;
    logic [5:0]       color;
    status_e          status;
    logic             last;
  } color_word_t;

  int unsigned errors = 0;

  // one mismatch line, counted
  function automatic void report(input string what);
    errors++;
    $display("ERROR %0t: %s", $realtime, what);
  endfunction

  // predictor and store of expected words
  class color_board;
    logic [6:0]  obj_mark [256];
    logic [5:0]  pcolor [64];
    logic [15:0] pweight [64];
    logic [7:0]  open_objs [8];
    int          open_cnt;
    bit          open_ovfl;
    logic [6:0]  open_max;
    int          npairs;
    logic [6:0]  first_sets;
    color_word_t pending [$];
    int          words_seen;

    function void clear_all();
      foreach (obj_mark[i]) obj_mark[i] = '0;
      open_cnt = 0; open_ovfl = 0; open_max = '0; npairs = 0;
    endfunction

    function void push(kind_e k, int i, int c, status_e s, bit l);
      color_word_t w;
      w.kind = k; w.idx = 6'(i); w.color = 6'(c); w.status = s; w.last = l;
      pending.push_back(w);
    endfunction

    // note one accepted input word
    function void note_input(mode_e m, logic [7:0] oid, logic [15:0] cc);
      int c, n;
      int ord [$];
      case (m)
        MODE_OBJ: begin
          if (open_cnt < MaxObjsPerPair) begin
            open_objs[open_cnt] = oid;
            open_cnt++;
            if (obj_mark[oid] > open_max) open_max = obj_mark[oid];
          end else open_ovfl = 1;
        end
        MODE_CLOSE: begin
          if (npairs >= MaxPairs) begin
            push(KIND_PAIR, 0, 0, STAT_FULL, 0);
          end else begin
            c = (npairs < first_sets) ? 0 : open_max;
            if (c > ColorMax) c = ColorMax;
            pcolor[npairs] = 6'(c);
            pweight[npairs] = cc;
            for (int i = 0; i < open_cnt; i++) obj_mark[open_objs[i]] = 7'(c + 1);
            push(KIND_PAIR, npairs, c, open_ovfl ? STAT_OBJ_OVFL : STAT_OK, 0);
            npairs++;
          end
          open_cnt = 0; open_ovfl = 0; open_max = '0;
        end
        MODE_FINISH: begin
          n = npairs;
          if (n == 0) push(KIND_EMPTY, 0, 0, STAT_OK, 1);
          else begin
            // insertion by color, weight desc, index
            for (int i = 0; i < n; i++) begin
              int j;
              j = 0;
              while (j < ord.size() && (pcolor[ord[j]] < pcolor[i] ||
                     (pcolor[ord[j]] == pcolor[i] && pweight[ord[j]] >= pweight[i])))
                j++;
              ord.insert(j, i);
            end
            foreach (ord[i]) push(KIND_SET, ord[i], pcolor[ord[i]], STAT_OK, i == n - 1);
          end
          clear_all();
        end
        default: ;
      endcase
    endfunction

    // check one accepted output word
    function void check_word(color_word_t got);
      color_word_t exp_w;
      words_seen++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word %p", got));
        return;
      end
      exp_w = pending.pop_front();
      if (got.kind !== exp_w.kind) report($sformatf("kind %0d want %0d", got.kind, exp_w.kind));
      if (got.idx !== exp_w.idx) report($sformatf("index %0d want %0d", got.idx, exp_w.idx));
      if (got.color !== exp_w.color)
        report($sformatf("color %0d want %0d", got.color, exp_w.color));
      if (got.status !== exp_w.status)
        report($sformatf("status %0d want %0d", got.status, exp_w.status));
      if (got.last !== exp_w.last) report($sformatf("last %0d want %0d", got.last, exp_w.last));
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i = '0;

  color_board board = new();
  longint cycles = 0;
  int     n_items = 0;
  bit     rx_quiet = 0;

  always #5 clk_i = ~clk_i;

  greedy_partition_pair_coloring DUT (.*);

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stalls, checks every accepted word
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = rx_quiet ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
      if (gap > 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_word({kind_e'(m_axis_tuser), m_axis_tdata[5:0], m_axis_tdata[11:6],
                        status_e'(m_axis_tdata[13:12]), m_axis_tlast});
    end
  end

  // send one input word, then idle a random gap
  task automatic send(input mode_e m, input logic [7:0] oid, input logic [15:0] cc,
                      input bit gaps = 1);
    int gap;
    s_axis_tvalid <= 1;
    s_axis_tuser <= m;
    s_axis_tdata <= {cc, oid};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_input(m, oid, cc);
    if (m != MODE_NONE) n_items++;
    gap = gaps ? $urandom_range(0, 14) : 0;
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // wait until nothing is pending, plus finish latency margin
  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (64 * 70) @(posedge clk_i);
  endtask

  task automatic set_first(input int v);
    cfg_valid_i <= 1;
    cfg_data_i <= 7'(v);
    do @(posedge clk_i); while (!cfg_ready_o);
    board.first_sets = 7'(v);
    cfg_valid_i <= 0;
  endtask

  // one well formed pair with random objects drawn from a pool
  task automatic rand_pair(input int pool);
    int no;
    no = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 8);
    repeat (no) send(MODE_OBJ, 8'($urandom_range(0, pool)), 16'($urandom()));
    send(MODE_CLOSE, 8'($urandom()),
         16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom()));
  endtask

  initial begin
    int fs [5];
    fs = '{64, 127, 3, 0, 20};
    board.clear_all();
    board.first_sets = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty finish, extremes, overflow, ignored mode
    send(MODE_FINISH, 0, 0);
    send(MODE_OBJ, 8'h00, 16'hFFFF);
    send(MODE_OBJ, 8'hFF, 16'h0000);
    send(MODE_CLOSE, 8'hFF, 16'hFFFF);
    send(MODE_OBJ, 8'hFF, 0);
    send(MODE_NONE, 8'hAA, 16'h5555);
    send(MODE_CLOSE, 0, 16'h0000);
    repeat (10) send(MODE_OBJ, 8'h55, 0);
    send(MODE_CLOSE, 0, 16'hFFFF);
    send(MODE_OBJ, 8'h12, 0);
    send(MODE_FINISH, 0, 0);
    drain();

    // table full: chain colors up to the cap, then overflow the pair table
    set_first(0);
    for (int i = 0; i < 66; i++) begin
      send(MODE_OBJ, 8'h07, 0, 0);
      send(MODE_CLOSE, 0, i[15:0], 0);
    end
    send(MODE_FINISH, 0, 0);
    drain();

    // random phases with several register settings
    for (int k = 0; k < 5; k++) begin
      set_first(fs[k]);
      rx_quiet = (k == 2);
      for (int p = 0; p < 4; p++) begin
        rand_pair((k == 4) ? 255 : 15);
        if ($urandom_range(0, 15) == 0) send(MODE_NONE, 8'($urandom()), 16'($urandom()));
      end
      if (k == 1) begin
        // hold off until all close words are back
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge clk_i);
      end
      for (int p = 0; p < 3; p++) rand_pair(7);
      send(MODE_FINISH, 8'($urandom()), 16'($urandom()));
      drain();
    end
    rx_quiet = 0;
    while (n_items < 360) begin
      rand_pair(31);
      if ($urandom_range(0, 10) == 0) send(MODE_FINISH, 0, 0);
    end
    send(MODE_FINISH, 0, 0);
    drain();

    $display("Covered %0d input words, %0d output words, first-set counts 0 to 127,",
             n_items, board.words_seen);
    $display("object overflow, pair table overflow and color chains.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/gpc_pkg.sv
hw/rtl/gpc_mark_mem.sv
hw/rtl/gpc_pair_mem.sv
hw/rtl/greedy_partition_pair_coloring.sv
hw/rtl/gpc_checker.sv
verif/testbench.sv
